>>> rtl/alto_pkg.sv
`timescale 1ns / 1ps

package alto_pkg;

    // Field and register widths
    localparam int FIX_W      = 27;
    localparam int HEAD_W     = 18;
    localparam int OUT_W      = 29;
    localparam int AOFF_W     = 18;
    localparam int AZ_W       = 18;
    localparam int TWR_W      = 20;
    localparam int SHIFT_W    = 28;
    localparam int CFG_DATA_W = 28;
    localparam int CFG_IDX_W  = 3;

    // Internal datapath widths
    localparam int ANG_W  = 20;            // negated heading sum, 1/256 degree
    localparam int ARM_W  = 21;            // antenna offset minus tower joint
    localparam int SW     = 30;            // fix minus site shift
    localparam int CW     = 31;            // CORDIC x / y with guard bits
    localparam int ZW     = 33;            // CORDIC residual angle, 2^-24 degree
    localparam int SAT_W  = SW + 1;

    localparam int ARM_GUARD = 8;
    localparam int Z_SHIFT   = 16;

    // Rotation setup
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_DEPTH    = 24;
    localparam int NUM_CELLS     = (CORDIC_STAGES < ATAN_DEPTH) ? CORDIC_STAGES : ATAN_DEPTH;
    localparam int SHAMT_W       = $clog2(ATAN_DEPTH);

    // Gain correction and rounding
    localparam int GAIN_W      = 31;
    localparam int PROD_W      = CW + GAIN_W;
    localparam int SCALE_SHIFT = 30 + ARM_GUARD;
    localparam int RX_W        = PROD_W - SCALE_SHIFT;

    localparam logic signed [GAIN_W-1:0] GAIN_Q30   = GAIN_W'(652032874);
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (SCALE_SHIFT - 1);

    // Angle limits, 1/256 degree
    localparam logic signed [ANG_W-1:0] TURN         = ANG_W'(92160);
    localparam logic signed [ANG_W-1:0] TWO_TURNS    = ANG_W'(184320);
    localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(46080);
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(23040);

    // atan(2^-i) in 2^-24 degree
    localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_DEPTH] = '{
        ZW'(754974720), ZW'(445687602), ZW'(235489088), ZW'(119537938),
        ZW'(60000934),  ZW'(30029717),  ZW'(15018523),  ZW'(7509720),
        ZW'(3754917),   ZW'(1877466),   ZW'(938734),    ZW'(469367),
        ZW'(234684),    ZW'(117342),    ZW'(58671),     ZW'(29335),
        ZW'(14668),     ZW'(7334),      ZW'(3667),      ZW'(1833),
        ZW'(917),       ZW'(458),       ZW'(229),       ZW'(115)
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANT_X   = 3'd0,
        CFG_ANT_Y   = 3'd1,
        CFG_AZ_OFF  = 3'd2,
        CFG_TOWER_X = 3'd3,
        CFG_TOWER_Y = 3'd4,
        CFG_SHIFT_E = 3'd5,
        CFG_SHIFT_N = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [AOFF_W-1:0]  antenna_offset_x;
        logic signed [AOFF_W-1:0]  antenna_offset_y;
        logic signed [AZ_W-1:0]    azimuth_offset;
        logic signed [TWR_W-1:0]   tower_x;
        logic signed [TWR_W-1:0]   tower_y;
        logic signed [SHIFT_W-1:0] site_shift_east;
        logic signed [SHIFT_W-1:0] site_shift_north;
    } cfg_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic signed [SW-1:0] se;
        logic signed [SW-1:0] sn;
    } cordic_t;

    // Clamp to the signed output range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-OUT_W:0] hi_bits;
        hi_bits = v[SAT_W-1:OUT_W-1];
        if (hi_bits == '0 || hi_bits == '1)
            return v[OUT_W-1:0];
        else if (v[SAT_W-1])
            return {1'b1, {(OUT_W-1){1'b0}}};
        else
            return {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

endpackage

>>> rtl/alto_fix_if.sv
`timescale 1ns / 1ps

interface alto_fix_if import alto_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic        [FIX_W-1:0]  fix_east;
    logic        [FIX_W-1:0]  fix_north;
    logic signed [HEAD_W-1:0] heading;

    modport source (output valid, output fix_east, output fix_north, output heading,
                    input ready);
    modport sink   (input valid, input fix_east, input fix_north, input heading,
                    output ready);
endinterface

>>> rtl/alto_res_if.sv
`timescale 1ns / 1ps

interface alto_res_if import alto_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] tower_east;
    logic signed [OUT_W-1:0] tower_north;
    logic signed [OUT_W-1:0] shifted_east;
    logic signed [OUT_W-1:0] shifted_north;

    modport source (output valid, output tower_east, output tower_north,
                    output shifted_east, output shifted_north, input ready);
    modport sink   (input valid, input tower_east, input tower_north,
                    input shifted_east, input shifted_north, output ready);
endinterface

>>> rtl/alto_front.sv
`timescale 1ns / 1ps

module alto_front import alto_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    alto_fix_if.sink fix,
    output logic     out_valid,
    input  logic     out_ready,
    output cordic_t  out_data
);

    typedef struct packed {
        logic signed [ARM_W-1:0] x;
        logic signed [ARM_W-1:0] y;
        logic signed [SW-1:0]    se;
        logic signed [SW-1:0]    sn;
    } side_t;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;

    logic signed [ANG_W-1:0] s1_ang_reg, s1_ang_next;
    logic signed [ANG_W-1:0] s2_ang_reg, s2_ang_next;
    side_t                   s1_side_reg, s1_side_next;
    side_t                   s2_side_reg;
    cordic_t                 s3_data_reg, s3_data_next;

    logic signed [ANG_W-1:0] wrap_ang;
    logic signed [ANG_W-1:0] fold_ang;
    logic                    fold_neg;
    logic signed [ARM_W-1:0] arm_x, arm_y;

    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign fix.ready = s1_ready;

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

    // Stage 1: negated angle sum, lever arm, site shift
    always_comb
    begin
        s1_ang_next     = -(ANG_W'(fix.heading) + ANG_W'(cfg.azimuth_offset));
        s1_side_next.x  = ARM_W'(cfg.antenna_offset_x) - ARM_W'(cfg.tower_x);
        s1_side_next.y  = ARM_W'(cfg.antenna_offset_y) - ARM_W'(cfg.tower_y);
        s1_side_next.se = SW'($signed({1'b0, fix.fix_east})) - SW'(cfg.site_shift_east);
        s1_side_next.sn = SW'($signed({1'b0, fix.fix_north})) - SW'(cfg.site_shift_north);
    end

    // Stage 2: truncating remainder by one turn
    always_comb
    begin
        priority if (s1_ang_reg >= TWO_TURNS)
            s2_ang_next = s1_ang_reg - TWO_TURNS;
        else if (s1_ang_reg >= TURN)
            s2_ang_next = s1_ang_reg - TURN;
        else if (s1_ang_reg <= -TWO_TURNS)
            s2_ang_next = s1_ang_reg + TWO_TURNS;
        else if (s1_ang_reg <= -TURN)
            s2_ang_next = s1_ang_reg + TURN;
        else
            s2_ang_next = s1_ang_reg;
    end

    // Stage 3: wrap to a half turn, fold into a quarter turn, scale up
    always_comb
    begin
        priority if (s2_ang_reg > HALF_TURN)
            wrap_ang = s2_ang_reg - TURN;
        else if (s2_ang_reg < -HALF_TURN)
            wrap_ang = s2_ang_reg + TURN;
        else
            wrap_ang = s2_ang_reg;

        priority if (wrap_ang > QUARTER_TURN)
        begin
            fold_ang = wrap_ang - HALF_TURN;
            fold_neg = 1'b1;
        end
        else if (wrap_ang < -QUARTER_TURN)
        begin
            fold_ang = wrap_ang + HALF_TURN;
            fold_neg = 1'b1;
        end
        else
        begin
            fold_ang = wrap_ang;
            fold_neg = 1'b0;
        end

        arm_x = fold_neg ? -s2_side_reg.x : s2_side_reg.x;
        arm_y = fold_neg ? -s2_side_reg.y : s2_side_reg.y;

        s3_data_next.x  = CW'(arm_x) <<< ARM_GUARD;
        s3_data_next.y  = CW'(arm_y) <<< ARM_GUARD;
        s3_data_next.z  = ZW'(fold_ang) <<< Z_SHIFT;
        s3_data_next.se = s2_side_reg.se;
        s3_data_next.sn = s2_side_reg.sn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= fix.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fix.valid && s1_ready)
        begin
            s1_ang_reg  <= s1_ang_next;
            s1_side_reg <= s1_side_next;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_ang_reg  <= s2_ang_next;
            s2_side_reg <= s1_side_reg;
        end
        if (s2_valid_reg && s3_ready)
            s3_data_reg <= s3_data_next;
    end

endmodule

>>> rtl/alto_cell.sv
`timescale 1ns / 1ps

module alto_cell import alto_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SHAMT_W-1:0]   shamt,
    input  logic signed [ZW-1:0] atan,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cordic_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cordic_t              out_data
);

    logic                 valid_reg;
    cordic_t              data_reg, data_next;
    logic signed [CW-1:0] dx, dy;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // One micro-rotation; arithmetic shift is a floor shift
    always_comb
    begin
        dx = in_data.y >>> shamt;
        dy = in_data.x >>> shamt;
        data_next.se = in_data.se;
        data_next.sn = in_data.sn;
        if (!in_data.z[ZW-1])
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - atan;
        end
        else
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + atan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

>>> rtl/alto_back.sv
`timescale 1ns / 1ps

module alto_back import alto_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  cordic_t    in_data,
    alto_res_if.source result
);

    logic b1_valid_reg, b2_valid_reg, b3_valid_reg;
    logic b1_ready, b2_ready, b3_ready;

    logic signed [PROD_W-1:0] px_reg, py_reg, px_next, py_next;
    logic signed [SW-1:0]     b1_se_reg, b1_sn_reg, b2_se_reg, b2_sn_reg;
    logic signed [PROD_W-1:0] sum_x, sum_y;
    logic signed [RX_W-1:0]   rx_reg, ry_reg, rx_next, ry_next;

    logic signed [OUT_W-1:0]  tower_east_reg, tower_north_reg;
    logic signed [OUT_W-1:0]  shifted_east_reg, shifted_north_reg;
    logic signed [OUT_W-1:0]  tower_east_next, tower_north_next;
    logic signed [OUT_W-1:0]  shifted_east_next, shifted_north_next;

    assign b3_ready = !b3_valid_reg || result.ready;
    assign b2_ready = !b2_valid_reg || b3_ready;
    assign b1_ready = !b1_valid_reg || b2_ready;
    assign in_ready = b1_ready;

    assign result.valid         = b3_valid_reg;
    assign result.tower_east    = tower_east_reg;
    assign result.tower_north   = tower_north_reg;
    assign result.shifted_east  = shifted_east_reg;
    assign result.shifted_north = shifted_north_reg;

    // Gain correction multiply
    assign px_next = in_data.x * GAIN_Q30;
    assign py_next = in_data.y * GAIN_Q30;

    // Round half up and drop guard and gain fraction bits
    always_comb
    begin
        sum_x   = px_reg + ROUND_BIAS;
        sum_y   = py_reg + ROUND_BIAS;
        rx_next = sum_x[PROD_W-1:SCALE_SHIFT];
        ry_next = sum_y[PROD_W-1:SCALE_SHIFT];
    end

    // Remove rotated arm and clamp
    always_comb
    begin
        tower_east_next    = sat_out(SAT_W'(b2_se_reg) - SAT_W'(rx_reg));
        tower_north_next   = sat_out(SAT_W'(b2_sn_reg) - SAT_W'(ry_reg));
        shifted_east_next  = sat_out(SAT_W'(b2_se_reg));
        shifted_north_next = sat_out(SAT_W'(b2_sn_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
        end
        else
        begin
            if (b1_ready)
                b1_valid_reg <= in_valid;
            if (b2_ready)
                b2_valid_reg <= b1_valid_reg;
            if (b3_ready)
                b3_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && b1_ready)
        begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            b1_se_reg <= in_data.se;
            b1_sn_reg <= in_data.sn;
        end
        if (b1_valid_reg && b2_ready)
        begin
            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            b2_se_reg <= b1_se_reg;
            b2_sn_reg <= b1_sn_reg;
        end
        if (b2_valid_reg && b3_ready)
        begin
            tower_east_reg    <= tower_east_next;
            tower_north_reg   <= tower_north_next;
            shifted_east_reg  <= shifted_east_next;
            shifted_north_reg <= shifted_north_next;
        end
    end

endmodule

>>> rtl/antenna_offset_to_tower_position_top.sv
// Pipeline: three setup stages, one cell per CORDIC iteration, three gain/round/clamp
//   stages; every stage is a registered cell with its own valid.
// Throughput: one fix per cycle while result.ready does not stall the chain.
// Reset: rst_n clears all stage valids and the seven configuration registers to zero.
//   There is no clearing pass; the block takes a fix in the first cycle after reset.
`timescale 1ns / 1ps

module antenna_offset_to_tower_position_top import alto_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    alto_fix_if.sink              fix,
    alto_res_if.source            result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers; each takes the low bits of the write data.
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ANT_X:   cfg_reg.antenna_offset_x <= cfg_data[AOFF_W-1:0];
                CFG_ANT_Y:   cfg_reg.antenna_offset_y <= cfg_data[AOFF_W-1:0];
                CFG_AZ_OFF:  cfg_reg.azimuth_offset   <= cfg_data[AZ_W-1:0];
                CFG_TOWER_X: cfg_reg.tower_x          <= cfg_data[TWR_W-1:0];
                CFG_TOWER_Y: cfg_reg.tower_y          <= cfg_data[TWR_W-1:0];
                CFG_SHIFT_E: cfg_reg.site_shift_east  <= cfg_data[SHIFT_W-1:0];
                CFG_SHIFT_N: cfg_reg.site_shift_north <= cfg_data[SHIFT_W-1:0];
                default:     ;  // unused index: drop the write
            endcase
        end
    end

    // Chain links: element 0 is the front-end output, element NUM_CELLS feeds the back end.
    logic    link_valid [NUM_CELLS+1];
    logic    link_ready [NUM_CELLS+1];
    cordic_t link_data  [NUM_CELLS+1];

    // Angle setup: sum and negate heading, reduce to a quarter turn, form the lever arm.
    alto_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .fix       (fix),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_data  (link_data[0])
    );

    // Rotation: one cell per iteration, each with a fixed shift and arctangent.
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        alto_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .shamt     (SHAMT_W'(i)),
            .atan      (ATAN_TAB[i]),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_data   (link_data[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_data  (link_data[i+1])
        );
    end

    // Gain correction, rounding, arm removal and clamp; ends in the output register.
    alto_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (link_valid[NUM_CELLS]),
        .in_ready (link_ready[NUM_CELLS]),
        .in_data  (link_data[NUM_CELLS]),
        .result   (result)
    );

endmodule
